@@ hdl/frti_pkg.sv @@
package frti_pkg;

  localparam int SPEED_POINTS_DEF    = 16;
  localparam int PRESSURE_POINTS_DEF = 16;
  localparam int COOLANT_POINTS_DEF  = 16;

  localparam logic [1:0] REQ_GAS  = 2'd0;
  localparam logic [1:0] REQ_ETH  = 2'd1;
  localparam logic [1:0] REQ_COOL = 2'd2;
  localparam logic [1:0] REQ_CMP  = 2'd3;

  localparam logic [1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [1:0] CFG_MAX_PRESS = 2'd1;
  localparam logic [1:0] CFG_MIN_COOL  = 2'd2;
  localparam logic [1:0] CFG_MAX_COOL  = 2'd3;

  localparam int FRAC_W    = 10;
  localparam int DIV_W     = 26;
  localparam int REM_W     = 17;
  localparam int DSR_W     = 16;
  localparam int STEPS_PER = 2;
  localparam int DIV_ST    = DIV_W / STEPS_PER;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] quo;
  } div_state_t;

  function automatic div_state_t div_steps(input div_state_t s, input logic [DSR_W-1:0] d);
    div_state_t r;
    r = s;
    for (int k = 0; k < STEPS_PER; k++) begin
      r.rem = {r.rem[REM_W-2:0], r.quo[DIV_W-1]};
      r.quo = {r.quo[DIV_W-2:0], 1'b0};
      if (r.rem >= {1'b0, d}) begin
        r.rem    = r.rem - {1'b0, d};
        r.quo[0] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/frti_ram.sv @@
module frti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fuel_ratio_table_interpolator_unit.sv @@
// Target air-fuel ratio from gasoline and ethanol speed-by-pressure tables and a coolant
// gain table. One item enters per clock (busy stays low); a compute item gives its result
// on afr_q10/saturated with a one-cycle done strobe, after the input register, the 26-bit
// axis divider (two quotient bits per stage) and the table and multiply registers. Load
// items give no result and take effect in issue order. Results cannot be held off. Tables
// hold no reset value: load every entry a compute will touch before using it.
module fuel_ratio_table_interpolator_unit import frti_pkg::*; #(
  parameter int SPEED_POINTS    = SPEED_POINTS_DEF,
  parameter int PRESSURE_POINTS = PRESSURE_POINTS_DEF,
  parameter int COOLANT_POINTS  = COOLANT_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [7:0]        entry_index,
  input  logic [15:0]       entry_value,
  input  logic [15:0]       speed_rpm,
  input  logic [9:0]        pressure_kpa,
  input  logic signed [8:0] coolant_c,
  input  logic [10:0]       ethanol_fraction,
  output logic              done,
  output logic [16:0]       afr_q10,
  output logic              saturated,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int SIW = $clog2(SPEED_POINTS);
  localparam int PIW = $clog2(PRESSURE_POINTS);
  localparam int CIW = $clog2(COOLANT_POINTS);
  localparam int S_SH = 16 + SIW;
  localparam int P_SH = 10 + PIW;
  localparam int C_SH = 9 + CIW;
  localparam longint S_MUL = ((64'd1 << S_SH) + SPEED_POINTS - 1) / SPEED_POINTS;
  localparam longint P_MUL = ((64'd1 << P_SH) + PRESSURE_POINTS - 1) / PRESSURE_POINTS;
  localparam longint C_MUL = ((64'd1 << C_SH) + COOLANT_POINTS - 1) / COOLANT_POINTS;
  localparam int SPW = 16 + 17;
  localparam int PPW = 10 + 11;
  localparam int CPW = 9 + 10;
  localparam logic [10:0] ONE = 11'd1024;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [15:0]       max_speed;
  logic [9:0]        max_press;
  logic signed [8:0] min_cool;
  logic signed [8:0] max_cool;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= 16'd8000;
      max_press <= 10'd256;
      min_cool  <= -9'sd40;
      max_cool  <= 9'sd120;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SPEED: max_speed <= cfg_data;
        CFG_MAX_PRESS: max_press <= cfg_data[9:0];
        CFG_MIN_COOL:  min_cool  <= cfg_data[8:0];
        CFG_MAX_COOL:  max_cool  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [SPW-1:0]    sp_prod;
  logic [PPW-1:0]    pr_prod;
  logic [CPW-1:0]    co_prod;
  logic [15:0]       sstep;
  logic [9:0]        pstep;
  logic [8:0]        cstep;
  logic signed [9:0] cdiff;
  logic signed [9:0] toff;
  logic [8:0]        tpos;
  logic [10:0]       eth_c;

  always_comb begin
    sp_prod = SPW'(max_speed) * SPW'(S_MUL);
    pr_prod = PPW'(max_press) * PPW'(P_MUL);
    sstep = 16'(sp_prod >> S_SH);
    pstep = 10'(pr_prod >> P_SH);
    if (sstep == 16'd0) begin
      sstep = 16'd1;
    end
    if (pstep == 10'd0) begin
      pstep = 10'd1;
    end
    cdiff = {max_cool[8], max_cool} - {min_cool[8], min_cool};
    co_prod = CPW'(cdiff[8:0]) * CPW'(C_MUL);
    cstep = 9'(co_prod >> C_SH);
    if (cdiff <= 10'sd0 || cstep == 9'd0) begin
      cstep = 9'd1;
    end
    toff = {coolant_c[8], coolant_c} - {min_cool[8], min_cool};
    tpos = (toff < 10'sd0) ? 9'd0 : toff[8:0];
    eth_c = (ethanol_fraction > ONE) ? ONE : ethanol_fraction;
  end

  logic             v   [0:DIV_ST];
  logic [1:0]       req [0:DIV_ST];
  logic [7:0]       idx [0:DIV_ST];
  logic [15:0]      val [0:DIV_ST];
  logic [10:0]      eth [0:DIV_ST];
  div_state_t       ds  [0:DIV_ST][0:2];
  logic [DSR_W-1:0] dsr [0:DIV_ST][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= start && !busy;
    end
    req[0] <= req_type;
    idx[0] <= entry_index;
    val[0] <= entry_value;
    eth[0] <= eth_c;
    ds[0][0] <= '{rem: '0, quo: {speed_rpm, 10'd0}};
    ds[0][1] <= '{rem: '0, quo: {6'd0, pressure_kpa, 10'd0}};
    ds[0][2] <= '{rem: '0, quo: {7'd0, tpos, 10'd0}};
    dsr[0][0] <= sstep;
    dsr[0][1] <= {6'd0, pstep};
    dsr[0][2] <= {7'd0, cstep};
  end

  for (genvar st = 1; st <= DIV_ST; st++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        v[st] <= 1'b0;
      end else begin
        v[st] <= v[st-1];
      end
      req[st] <= req[st-1];
      idx[st] <= idx[st-1];
      val[st] <= val[st-1];
      eth[st] <= eth[st-1];
      for (int l = 0; l < 3; l++) begin
        ds[st][l]  <= div_steps(ds[st-1][l], dsr[st-1][l]);
        dsr[st][l] <= dsr[st-1][l];
      end
    end
  end

  logic [15:0]    qs, qp, qc;
  logic [SIW-1:0] sl, sh;
  logic [PIW-1:0] pl, ph;
  logic [CIW-1:0] cl, ch;
  logic [9:0]     fs, fp, fc;

  always_comb begin
    qs = ds[DIV_ST][0].quo[DIV_W-1:FRAC_W];
    qp = ds[DIV_ST][1].quo[DIV_W-1:FRAC_W];
    qc = ds[DIV_ST][2].quo[DIV_W-1:FRAC_W];
    if (qs > 16'(SPEED_POINTS - 1)) begin
      sl = SIW'(SPEED_POINTS - 1);
      sh = SIW'(SPEED_POINTS - 1);
      fs = 10'd0;
    end else begin
      sl = qs[SIW-1:0];
      sh = (qs == 16'(SPEED_POINTS - 1)) ? sl : sl + SIW'(1);
      fs = ds[DIV_ST][0].quo[FRAC_W-1:0];
    end
    if (qp > 16'(PRESSURE_POINTS - 1)) begin
      pl = PIW'(PRESSURE_POINTS - 1);
      ph = PIW'(PRESSURE_POINTS - 1);
      fp = 10'd0;
    end else begin
      pl = qp[PIW-1:0];
      ph = (qp == 16'(PRESSURE_POINTS - 1)) ? pl : pl + PIW'(1);
      fp = ds[DIV_ST][1].quo[FRAC_W-1:0];
    end
    if (qc > 16'(COOLANT_POINTS - 1)) begin
      cl = CIW'(COOLANT_POINTS - 1);
      ch = CIW'(COOLANT_POINTS - 1);
      fc = 10'd0;
    end else begin
      cl = qc[CIW-1:0];
      ch = (qc == 16'(COOLANT_POINTS - 1)) ? cl : cl + CIW'(1);
      fc = ds[DIV_ST][2].quo[FRAC_W-1:0];
    end
  end

  logic           a_v;
  logic [1:0]     a_req;
  logic [7:0]     a_idx;
  logic [15:0]    a_val;
  logic [10:0]    a_eth;
  logic [7:0]     a_addr [0:3];
  logic [CIW-1:0] a_cl, a_ch;
  logic [9:0]     a_fs, a_fp, a_fc;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= v[DIV_ST];
    end
    a_req <= req[DIV_ST];
    a_idx <= idx[DIV_ST];
    a_val <= val[DIV_ST];
    a_eth <= eth[DIV_ST];
    a_addr[0] <= 8'(16'(sl) + 16'(SPEED_POINTS) * 16'(pl));
    a_addr[1] <= 8'(16'(sh) + 16'(SPEED_POINTS) * 16'(pl));
    a_addr[2] <= 8'(16'(sl) + 16'(SPEED_POINTS) * 16'(ph));
    a_addr[3] <= 8'(16'(sh) + 16'(SPEED_POINTS) * 16'(ph));
    a_cl <= cl;
    a_ch <= ch;
    a_fs <= fs;
    a_fp <= fp;
    a_fc <= fc;
  end

  logic        gas_we, eth_we, cool_we;
  logic [15:0] gas_d [0:3];
  logic [15:0] eth_d [0:3];
  logic [15:0] cool_lo, cool_hi;

  assign gas_we  = a_v && (a_req == REQ_GAS);
  assign eth_we  = a_v && (a_req == REQ_ETH);
  assign cool_we = a_v && (a_req == REQ_COOL) && (a_idx < 8'(COOLANT_POINTS));

  for (genvar c = 0; c < 4; c++) begin : g_ratio
    frti_ram #(.WIDTH(16), .DEPTH(256)) u_gas (
      .clk(clk), .we(gas_we), .waddr(a_idx), .wdata(a_val),
      .raddr(a_addr[c]), .rdata(gas_d[c])
    );
    frti_ram #(.WIDTH(16), .DEPTH(256)) u_eth (
      .clk(clk), .we(eth_we), .waddr(a_idx), .wdata(a_val),
      .raddr(a_addr[c]), .rdata(eth_d[c])
    );
  end

  frti_ram #(.WIDTH(16), .DEPTH(COOLANT_POINTS)) u_cool_lo (
    .clk(clk), .we(cool_we), .waddr(a_idx[CIW-1:0]), .wdata(a_val),
    .raddr(a_cl), .rdata(cool_lo)
  );
  frti_ram #(.WIDTH(16), .DEPTH(COOLANT_POINTS)) u_cool_hi (
    .clk(clk), .we(cool_we), .waddr(a_idx[CIW-1:0]), .wdata(a_val),
    .raddr(a_ch), .rdata(cool_hi)
  );

  logic        r_v;
  logic [10:0] r_eth;
  logic [9:0]  r_fs, r_fp, r_fc;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else begin
      r_v <= a_v && (a_req == REQ_CMP);
    end
    r_eth <= a_eth;
    r_fs  <= a_fs;
    r_fp  <= a_fp;
    r_fc  <= a_fc;
  end

  logic [10:0] ws0, ws1, wc0, wc1;
  assign ws1 = {1'b0, r_fs};
  assign ws0 = ONE - ws1;
  assign wc1 = {1'b0, r_fc};
  assign wc0 = ONE - wc1;

  logic        m1_v;
  logic [25:0] m1_g0, m1_g1, m1_e0, m1_e1, m1_gain;
  logic [10:0] m1_eth;
  logic [9:0]  m1_fp;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else begin
      m1_v <= r_v;
    end
    m1_g0   <= 26'(26'(gas_d[0]) * 26'(ws0) + 26'(gas_d[1]) * 26'(ws1));
    m1_g1   <= 26'(26'(gas_d[2]) * 26'(ws0) + 26'(gas_d[3]) * 26'(ws1));
    m1_e0   <= 26'(26'(eth_d[0]) * 26'(ws0) + 26'(eth_d[1]) * 26'(ws1));
    m1_e1   <= 26'(26'(eth_d[2]) * 26'(ws0) + 26'(eth_d[3]) * 26'(ws1));
    m1_gain <= 26'(26'(cool_lo) * 26'(wc0) + 26'(cool_hi) * 26'(wc1));
    m1_eth  <= r_eth;
    m1_fp   <= r_fp;
  end

  logic [10:0] wp0, wp1;
  assign wp1 = {1'b0, m1_fp};
  assign wp0 = ONE - wp1;

  logic        m2_v;
  logic [35:0] m2_gas, m2_etv;
  logic [25:0] m2_gain;
  logic [10:0] m2_eth;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else begin
      m2_v <= m1_v;
    end
    m2_gas  <= 36'(36'(m1_g0) * 36'(wp0) + 36'(m1_g1) * 36'(wp1));
    m2_etv  <= 36'(36'(m1_e0) * 36'(wp0) + 36'(m1_e1) * 36'(wp1));
    m2_gain <= m1_gain;
    m2_eth  <= m1_eth;
  end

  logic [45:0] blend_sum;
  assign blend_sum = 46'(m2_etv) * 46'(m2_eth) + 46'(m2_gas) * 46'(ONE - m2_eth);

  logic        m3_v;
  logic [25:0] m3_blend, m3_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else begin
      m3_v <= m2_v;
    end
    m3_blend <= blend_sum[45:20];
    m3_gain  <= m2_gain;
  end

  logic        m4_v;
  logic [51:0] m4_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_v <= 1'b0;
    end else begin
      m4_v <= m3_v;
    end
    m4_prod <= 52'(m3_blend) * 52'(m3_gain);
  end

  logic [17:0] afr_full;
  assign afr_full = m4_prod[51:34];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m4_v;
    end
    if (afr_full[17]) begin
      afr_q10   <= 17'h1FFFF;
      saturated <= 1'b1;
    end else begin
      afr_q10   <= afr_full[16:0];
      saturated <= 1'b0;
    end
  end

endmodule

@@ tb/fuel_ratio_table_interpolator_unit_tb.sv @@
module fuel_ratio_table_interpolator_unit_tb;
  import frti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SP = SPEED_POINTS_DEF;
  localparam int PP = PRESSURE_POINTS_DEF;
  localparam int CP = COOLANT_POINTS_DEF;
  localparam int SETTLE = 40;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [1:0]        req;
    logic [7:0]        idx;
    logic [15:0]       val;
    logic [15:0]       speed;
    logic [9:0]        press;
    logic signed [8:0] cool;
    logic [10:0]       eth;
  } fuel_req_t;

  typedef struct packed {
    logic [16:0] afr;
    logic        sat;
  } afr_res_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        req_type;
  logic [7:0]        entry_index;
  logic [15:0]       entry_value;
  logic [15:0]       speed_rpm;
  logic [9:0]        pressure_kpa;
  logic signed [8:0] coolant_c;
  logic [10:0]       ethanol_fraction;
  logic              done;
  logic [16:0]       afr_q10;
  logic              saturated;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;

  fuel_ratio_table_interpolator_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .entry_index(entry_index), .entry_value(entry_value),
    .speed_rpm(speed_rpm), .pressure_kpa(pressure_kpa), .coolant_c(coolant_c),
    .ethanol_fraction(ethanol_fraction), .done(done), .afr_q10(afr_q10),
    .saturated(saturated), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [15:0]       gas_tbl [256];
  logic [15:0]       eth_tbl [256];
  logic [15:0]       gain_tbl [CP];
  logic [15:0]       max_speed;
  logic [9:0]        max_press;
  logic signed [8:0] min_cool;
  logic signed [8:0] max_cool;

  fuel_req_t req_q[$];
  afr_res_t  afr_expect_q[$];
  fuel_req_t cur;
  int        errors;
  int        burst_left;
  int        gap_left;
  int        stall_cnt;

  function automatic void axis_locate(input int unsigned x, input int unsigned step,
                                      input int unsigned pts, output int unsigned lo,
                                      output int unsigned hi, output int unsigned fr);
    int unsigned q;
    if (step == 0) step = 1;
    q = x / step;
    if (q > pts - 1) begin
      lo = pts - 1;
      hi = pts - 1;
      fr = 0;
    end else begin
      lo = q;
      hi = (q + 1 > pts - 1) ? pts - 1 : q + 1;
      fr = ((x % step) << 10) / step;
    end
  endfunction

  function automatic longint unsigned blerp(input logic [15:0] t [256], input int unsigned sl,
                                            input int unsigned sh, input int unsigned pl,
                                            input int unsigned ph, input int unsigned fs,
                                            input int unsigned fp);
    longint unsigned ws0, ws1, wp0, wp1;
    ws0 = 64'(1024 - fs);
    ws1 = 64'(fs);
    wp0 = 64'(1024 - fp);
    wp1 = 64'(fp);
    return t[(sl + SP * pl) % 256] * ws0 * wp0 + t[(sh + SP * pl) % 256] * ws1 * wp0
         + t[(sl + SP * ph) % 256] * ws0 * wp1 + t[(sh + SP * ph) % 256] * ws1 * wp1;
  endfunction

  function automatic afr_res_t afr_predict(input fuel_req_t r);
    int unsigned     sl, sh, pl, ph, cl, ch, fs, fp, fc, eth;
    int              cstep, toff;
    longint unsigned gas, etv, blend, gain, afr;
    afr_res_t        res;
    eth = (r.eth > 11'd1024) ? 1024 : 32'(r.eth);
    axis_locate(32'(r.speed), 32'(max_speed) / SP, SP, sl, sh, fs);
    axis_locate(32'(r.press), 32'(max_press) / PP, PP, pl, ph, fp);
    cstep = (int'(max_cool) - int'(min_cool)) / CP;
    if (cstep < 1) cstep = 1;
    toff = int'(r.cool) - int'(min_cool);
    if (toff < 0) toff = 0;
    axis_locate(toff, cstep, CP, cl, ch, fc);
    gas = blerp(gas_tbl, sl, sh, pl, ph, fs, fp);
    etv = blerp(eth_tbl, sl, sh, pl, ph, fs, fp);
    blend = (etv * eth + gas * (1024 - eth)) >> 20;
    gain = longint'(gain_tbl[cl]) * (1024 - fc) + longint'(gain_tbl[ch]) * fc;
    afr = (blend * gain) >> 34;
    res.sat = afr > 131071;
    res.afr = res.sat ? 17'h1FFFF : afr[16:0];
    return res;
  endfunction

  function automatic fuel_req_t make_load(input logic [1:0] req, input int idx, input int val);
    fuel_req_t r;
    r = '0;
    r.req = req;
    r.idx = 8'(idx);
    r.val = 16'(val);
    r.speed = 16'($urandom);
    return r;
  endfunction

  function automatic fuel_req_t make_compute(input int speed, input int press, input int cool,
                                             input int eth);
    fuel_req_t r;
    r = '0;
    r.req = REQ_CMP;
    r.idx = 8'($urandom);
    r.val = 16'($urandom);
    r.speed = 16'(speed);
    r.press = 10'(press);
    r.cool = 9'(cool);
    r.eth = 11'(eth);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        case (cur.req)
          REQ_GAS:  gas_tbl[cur.idx] = cur.val;
          REQ_ETH:  eth_tbl[cur.idx] = cur.val;
          REQ_COOL: if (cur.idx < CP) gain_tbl[cur.idx] = cur.val;
          default:  afr_expect_q.push_back(afr_predict(cur));
        endcase
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (req_q.size() > 0) begin
          cur = req_q.pop_front();
          req_type <= cur.req;
          entry_index <= cur.idx;
          entry_value <= cur.val;
          speed_rpm <= cur.speed;
          pressure_kpa <= cur.press;
          coolant_c <= cur.cool;
          ethanol_fraction <= cur.eth;
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= int'($urandom_range(1, 60));
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (afr_expect_q.size() == 0) begin
        $display("%0t: unexpected result afr_q10=%0d saturated=%0d", $time, afr_q10, saturated);
        errors++;
      end else begin
        afr_res_t exp_r;
        exp_r = afr_expect_q.pop_front();
        if (afr_q10 !== exp_r.afr) begin
          $display("%0t: afr_q10 expected %0d actual %0d", $time, exp_r.afr, afr_q10);
          errors++;
        end
        if (saturated !== exp_r.sat) begin
          $display("%0t: saturated expected %0d actual %0d", $time, exp_r.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic wait_idle();
    do @(posedge clk); while (req_q.size() > 0 || start || afr_expect_q.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input int spd, input int prs, input int cmin, input int cmax);
    logic [15:0] vals [4];
    vals[CFG_MAX_SPEED] = 16'(spd);
    vals[CFG_MAX_PRESS] = 16'(prs);
    vals[CFG_MIN_COOL] = 16'(cmin);
    vals[CFG_MAX_COOL] = 16'(cmax);
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    max_speed = vals[CFG_MAX_SPEED];
    max_press = vals[CFG_MAX_PRESS][9:0];
    min_cool = vals[CFG_MIN_COOL][8:0];
    max_cool = vals[CFG_MAX_COOL][8:0];
  endtask

  task automatic add_random(input int n);
    int spd, prs, kind;
    for (int i = 0; i < n; i++) begin
      kind = int'($urandom_range(0, 9));
      spd = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                        : int'($urandom_range(0, max_speed + max_speed / SP));
      prs = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1023))
                                        : int'($urandom_range(0, max_press + max_press / PP));
      if (prs > 1023) prs = 1023;
      if (kind < 6)
        req_q.push_back(make_compute(spd, prs, int'($urandom_range(0, 319)) - 64,
                                     ($urandom_range(0, 4) == 0)
                                       ? int'(1024 * $urandom_range(0, 1))
                                       : int'($urandom_range(0, 1024))));
      else if (kind < 8)
        req_q.push_back(make_load(kind == 6 ? REQ_GAS : REQ_ETH, int'($urandom_range(0, 255)),
                                  int'($urandom_range(0, 65535))));
      else
        req_q.push_back(make_load(REQ_COOL, ($urandom_range(0, 3) == 0)
                                  ? int'($urandom_range(0, 255))
                                  : int'($urandom_range(0, CP - 1)),
                                  int'($urandom_range(0, 65535))));
    end
  endtask

  initial begin
    errors = 0;
    rst = 1'b1;
    req_type = REQ_GAS;
    entry_index = '0;
    entry_value = '0;
    speed_rpm = '0;
    pressure_kpa = '0;
    coolant_c = '0;
    ethanol_fraction = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_SPEED;
    cfg_data = '0;
    max_speed = 16'd8000;
    max_press = 10'd256;
    min_cool = -9'sd40;
    max_cool = 9'sd120;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 256; i++) begin
      req_q.push_back(make_load(REQ_GAS, i, int'($urandom_range(8000, 20000))));
      req_q.push_back(make_load(REQ_ETH, i, int'($urandom_range(6000, 12000))));
    end
    for (int i = 0; i < CP; i++)
      req_q.push_back(make_load(REQ_COOL, i, int'($urandom_range(12000, 24000))));
    req_q.push_back(make_load(REQ_GAS, 0, 16'hFFFF));
    req_q.push_back(make_load(REQ_ETH, 255, 16'hFFFF));
    req_q.push_back(make_load(REQ_COOL, 0, 16'hFFFF));
    req_q.push_back(make_load(REQ_COOL, 200, 16'h0000));
    req_q.push_back(make_compute(0, 0, -64, 0));
    req_q.push_back(make_compute(65535, 1023, 255, 1024));
    req_q.push_back(make_compute(7999, 255, 119, 512));
    req_q.push_back(make_compute(8000, 256, 120, 1023));
    req_q.push_back(make_compute(7500, 240, 110, 1));
    req_q.push_back(make_compute(250, 8, -50, 700));
    req_q.push_back(make_compute(16'h5555, 10'h2AA, 9'sh0AA, 11'h2AA));
    req_q.push_back(make_compute(16'hAAAA, 10'h155, 9'sh155, 11'h155));
    req_q.push_back(make_compute(499, 15, -39, 300));
    add_random(200);

    write_cfg(0, 0, 16'h01C0, 16'h01C0);
    add_random(180);
    write_cfg(65535, 1023, 255, 16'h01C0);
    add_random(180);
    write_cfg(65535, 1023, 16'h01C0, 255);
    add_random(180);
    write_cfg(15, 15, 10, 25);
    add_random(160);
    write_cfg(int'($urandom_range(0, 65535)), int'($urandom_range(0, 1023)),
              int'($urandom_range(0, 319)) - 64, int'($urandom_range(0, 319)) - 64);
    add_random(180);
    write_cfg(3000, 100, 0, 255);
    add_random(180);

    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
